[hw/rtl/tmcs_pkg.sv]
// Package for the texture mip chain size block.
// Holds format codes, operand widths and the format decode function.
// No dependencies.
package tmcs_pkg;

	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 48;
	localparam int ROW_W  = 20;

	localparam logic [31:0] FMT_DXT1 = 32'd827611204;
	localparam logic [31:0] FMT_DXT2 = 32'd844388420;
	localparam logic [31:0] FMT_DXT3 = 32'd861165636;
	localparam logic [31:0] FMT_DXT4 = 32'd877942852;
	localparam logic [31:0] FMT_DXT5 = 32'd894720068;

	typedef enum logic [2:0] {
		BPP_1 = 3'd0,
		BPP_2 = 3'd1,
		BPP_3 = 3'd2,
		BPP_4 = 3'd3,
		BPP_8 = 3'd4
	} bpp_t;

	typedef struct packed {
		logic is_block;
		logic block_big;
		bpp_t bpp;
	} fmt_info_t;

	function automatic fmt_info_t fmt_decode(input logic [31:0] fmt);
		fmt_info_t info;
		info.is_block  = 1'b0;
		info.block_big = 1'b0;
		info.bpp       = BPP_4;
		if (fmt == FMT_DXT1) begin
			info.is_block = 1'b1;
		end else if (fmt == FMT_DXT2 || fmt == FMT_DXT3 || fmt == FMT_DXT4
				|| fmt == FMT_DXT5) begin
			info.is_block  = 1'b1;
			info.block_big = 1'b1;
		end else begin
			case (fmt)
				32'd20: info.bpp = BPP_3;
				32'd23, 32'd24, 32'd25, 32'd26, 32'd27, 32'd30, 32'd40,
				32'd51, 32'd60, 32'd61, 32'd64: info.bpp = BPP_2;
				32'd28, 32'd41, 32'd50, 32'd52: info.bpp = BPP_1;
				32'd36: info.bpp = BPP_8;
				default: info.bpp = BPP_4;
			endcase
		end
		return info;
	endfunction

endpackage

[hw/rtl/texture_mip_chain_size.sv]
// Top level of the texture mip chain size block.
// Holds the level sequencer and accumulator. Depends on tmcs_pkg and tmcs_mul.
//
// Computes the byte size of a tightly packed mip chain from a format code and
// the top level width, height, depth and level count. One shared multiplier
// forms rows times depth and then row bytes times that for each level, for
// the level count after clamping to 1..MAX_LEVELS. The input is stalled while
// an item is in work. A finished result waits in an output register until it
// is taken; an item that finishes while that register is still full holds in
// its final step until it frees.
module texture_mip_chain_size import tmcs_pkg::*; #(
	parameter int MAX_LEVELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] format_code,
	input  logic [15:0]        width,
	input  logic [15:0]        height,
	input  logic [7:0]         depth,
	input  logic [4:0]         level_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        total_bytes,
	output logic               size_overflow
);

	localparam int LVL_W = $clog2(MAX_LEVELS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_TOT,
		S_FIN
	} state_t;

	state_t             state_q;
	fmt_info_t          fmt_q;
	logic [15:0]        w_q;
	logic [15:0]        h_q;
	logic [7:0]         d_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               pend_q;
	logic [ACC_W-1:0]   acc_q;
	logic               out_valid_q;
	logic [31:0]        total_q;
	logic               ovf_q;

	logic [MUL_W-1:0]   op_a;
	logic [MUL_W-1:0]   op_b;
	logic [PROD_W-1:0]  prod_q;
	logic [16:0]        w_plus;
	logic [16:0]        h_plus;
	logic [14:0]        bw;
	logic [14:0]        bh;
	logic [ROW_W-1:0]   row_bytes;
	logic [15:0]        rows;
	logic [4:0]         lc_clamp;
	logic               in_xfer;
	logic               fin_go;
	logic [ACC_W-1:0]   acc_sum;

	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign total_bytes = total_q;
	assign size_overflow = ovf_q;
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign w_plus = {1'b0, w_q} + 17'd3;
	assign h_plus = {1'b0, h_q} + 17'd3;

	always_comb begin
		bw = (w_plus[16:2] == '0) ? 15'd1 : w_plus[16:2];
		bh = (h_plus[16:2] == '0) ? 15'd1 : h_plus[16:2];
		if (fmt_q.is_block) begin
			rows = {1'b0, bh};
			if (fmt_q.block_big) begin
				row_bytes = ROW_W'({bw, 4'b0});
			end else begin
				row_bytes = ROW_W'({bw, 3'b0});
			end
		end else begin
			rows = h_q;
			case (fmt_q.bpp)
				BPP_1: row_bytes = ROW_W'(w_q);
				BPP_2: row_bytes = ROW_W'({w_q, 1'b0});
				BPP_3: row_bytes = ROW_W'({w_q, 1'b0}) + ROW_W'(w_q);
				BPP_4: row_bytes = ROW_W'({w_q, 2'b0});
				BPP_8: row_bytes = ROW_W'({w_q, 3'b0});
				default: row_bytes = ROW_W'({w_q, 2'b0});
			endcase
		end
	end

	always_comb begin
		if (state_q == S_TOT) begin
			op_a = MUL_W'(row_bytes);
			op_b = prod_q[MUL_W-1:0];
		end else begin
			op_a = MUL_W'(rows);
			op_b = MUL_W'(d_q);
		end
	end

	assign acc_sum = acc_q + (pend_q ? ACC_W'(prod_q) : ACC_W'(0));

	always_comb begin
		if (level_count == 5'd0) begin
			lc_clamp = 5'd1;
		end else if (level_count > 5'(MAX_LEVELS)) begin
			lc_clamp = 5'(MAX_LEVELS);
		end else begin
			lc_clamp = level_count;
		end
	end

	tmcs_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						fmt_q   <= fmt_decode($unsigned(format_code));
						w_q     <= width;
						h_q     <= height;
						d_q     <= (depth == 8'd0) ? 8'd1 : depth;
						lvl_q   <= LVL_W'(lc_clamp);
						pend_q  <= 1'b0;
						acc_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (pend_q) begin
						acc_q <= acc_sum;
					end
					state_q <= S_TOT;
				end
				S_TOT: begin
					w_q    <= (w_q > 16'd1) ? (w_q >> 1) : 16'd1;
					h_q    <= (h_q > 16'd1) ? (h_q >> 1) : 16'd1;
					d_q    <= (d_q > 8'd1) ? (d_q >> 1) : 8'd1;
					lvl_q  <= lvl_q - LVL_W'(1);
					pend_q <= 1'b1;
					if (lvl_q == LVL_W'(1)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					acc_q  <= acc_sum;
					pend_q <= 1'b0;
					if (fin_go) begin
						total_q <= acc_sum[31:0];
						ovf_q   <= |acc_sum[ACC_W-1:32];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (acc_q == '0 && state_q == S_RD))
		else $error("accumulator not cleared on input transfer");

	a_lvl_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_TOT) |-> (lvl_q != '0))
		else $error("level counter empty while a level is in work");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside the final step");

	a_fin_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOT) |=> pend_q)
		else $error("no product pending after a level step");

endmodule

[hw/rtl/tmcs_mul.sv]
// Shared multiplier of the texture mip chain size block.
// One unsigned product per cycle, registered. Depends on tmcs_pkg.
module tmcs_mul import tmcs_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule
